// File: rtl/core/assert_macros.svh
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// File: rtl/core/tild_pkg.sv
// shared types and constants of the terminal input line discipline
`default_nettype none

package tild_pkg;

    localparam logic OP_RECV = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARROW_UP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARROW_DOWN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARROW_RIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ARROW_LEFT  = 3'd4;

    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_BS      = 8'd8;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_ESC     = 8'd27;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_A       = 8'd65;
    localparam logic [7:0] CH_B       = 8'd66;
    localparam logic [7:0] CH_C       = 8'd67;
    localparam logic [7:0] CH_D       = 8'd68;
    localparam logic [7:0] CH_BRACKET = 8'd91;
    localparam logic [7:0] CH_DEL     = 8'd127;

    localparam logic [7:0] ARROW_UP_RESET    = 8'd128;
    localparam logic [7:0] ARROW_DOWN_RESET  = 8'd129;
    localparam logic [7:0] ARROW_RIGHT_RESET = 8'd130;
    localparam logic [7:0] ARROW_LEFT_RESET  = 8'd131;

    typedef enum logic [1:0] {
        ARROW_UP    = 2'd0,
        ARROW_DOWN  = 2'd1,
        ARROW_RIGHT = 2'd2,
        ARROW_LEFT  = 2'd3
    } arrow_t;

    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_EMPTY = 2'd2,
        KIND_QUIET = 2'd3
    } kind_t;

    // classified word passed from front to back
    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic       is_esc;
        logic       is_bracket;
        logic       is_nl;
        logic       is_del;
        logic       is_arrow;
        arrow_t     arrow;
    } tild_word_t;

    // queue handshake between front and back
    typedef struct packed {
        logic       valid;
        tild_word_t word;
    } tild_queue_t;

endpackage

`default_nettype wire

// File: rtl/core/tild_front.sv
// front end: accepts input words, classifies them and queues them for the back end
`default_nettype none

module tild_front
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire                  operation,
    input  wire  [7:0]           char_in,
    output tild_pkg::tild_queue_t q,
    input  wire                  q_pop
);
    import tild_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    tild_word_t            q_mem_reg [QDEPTH];
    logic [QPW-1:0]        wr_ptr_reg;
    logic [QPW-1:0]        wr_ptr_next;
    logic [QPW-1:0]        rd_ptr_reg;
    logic [QPW-1:0]        rd_ptr_next;
    logic [QCW-1:0]        count_reg;
    logic [QCW-1:0]        count_next;
    tild_word_t            cls;
    logic                  push;

    always_comb
    begin
        cls.op         = operation;
        cls.ch         = char_in;
        cls.is_esc     = (char_in == CH_ESC);
        cls.is_bracket = (char_in == CH_BRACKET);
        cls.is_nl      = (char_in == CH_LF) || (char_in == CH_CR);
        cls.is_del     = (char_in == CH_DEL);
        cls.is_arrow   = 1'b1;
        case (char_in)
            CH_A:    cls.arrow = ARROW_UP;
            CH_B:    cls.arrow = ARROW_DOWN;
            CH_C:    cls.arrow = ARROW_RIGHT;
            CH_D:    cls.arrow = ARROW_LEFT;
            default:
            begin
                cls.arrow    = ARROW_UP;
                cls.is_arrow = 1'b0;
            end
        endcase
    end

    assign in_stall = (count_reg == QCW'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q.valid  = (count_reg != '0);
    assign q.word   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tild_back.sv
// back end: buffers, escape tracking, line editing and the output register
`default_nettype none

module tild_back
#(
    parameter int FIFO_DEPTH = 16,
    parameter int LINE_LEN   = 64
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire  tild_pkg::tild_queue_t  q,
    output logic                         q_pop,
    input  wire                          cfg_write,
    input  wire  [tild_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [7:0]                   cfg_data,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [1:0]                   kind,
    output logic [7:0]                   data,
    output logic                         dropped,
    output logic                         last
);
    import tild_pkg::*;

    localparam int PW  = $clog2(FIFO_DEPTH);
    localparam int CW  = $clog2(FIFO_DEPTH + 1);
    localparam int LW  = $clog2(LINE_LEN);
    localparam int LAW = $clog2(2 * LINE_LEN);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DEL_SPACE,
        S_DEL_BS
    } state_t;

    state_t          state_reg, state_next;
    tild_word_t      cur_reg, cur_next;
    logic            line_mode_reg, line_mode_next;
    logic [7:0]      up_code_reg, up_code_next;
    logic [7:0]      down_code_reg, down_code_next;
    logic [7:0]      right_code_reg, right_code_next;
    logic [7:0]      left_code_reg, left_code_next;
    logic [PW-1:0]   fifo_wr_ptr_reg, fifo_wr_ptr_next;
    logic [PW-1:0]   fifo_rd_ptr_reg, fifo_rd_ptr_next;
    logic [CW-1:0]   fifo_count_reg, fifo_count_next;
    logic            write_bank_reg, write_bank_next;
    logic [LW-1:0]   write_len_reg, write_len_next;
    logic [LW-1:0]   read_len_reg, read_len_next;
    logic [LW-1:0]   read_pos_reg, read_pos_next;
    logic            read_active_reg, read_active_next;
    logic            esc_seen_reg, esc_seen_next;
    logic            csi_seen_reg, csi_seen_next;
    logic            out_valid_reg, out_valid_next;
    kind_t           kind_reg, kind_next;
    logic [7:0]      data_reg, data_next;
    logic            dropped_reg, dropped_next;
    logic            last_reg, last_next;

    logic [7:0]      fifo_mem [FIFO_DEPTH];
    logic [7:0]      line_mem [2 * LINE_LEN];
    logic [7:0]      fifo_rd_data_reg;
    logic [7:0]      line_rd_data_reg;

    logic            fifo_we;
    logic [7:0]      fifo_wdata;
    logic            line_we;
    logic [LAW-1:0]  line_waddr;
    logic [LAW-1:0]  line_raddr;
    logic            out_free;
    logic            emit;
    kind_t           e_kind;
    logic [7:0]      e_data;
    logic            e_dropped;
    logic            e_last;
    logic [7:0]      arrow_code;
    logic [7:0]      line_d;

    assign out_free   = !out_valid_reg || !out_stall;
    assign q_pop      = (state_reg == S_IDLE) && q.valid;
    assign line_waddr = write_bank_reg ? LAW'(LINE_LEN) + LAW'(write_len_reg)
                                       : LAW'(write_len_reg);
    assign line_raddr = write_bank_reg ? LAW'(read_pos_reg)
                                       : LAW'(LINE_LEN) + LAW'(read_pos_reg);
    assign line_d     = (read_pos_reg < read_len_reg) ? line_rd_data_reg : CH_NUL;

    always_comb
    begin
        case (cur_reg.arrow)
            ARROW_UP:    arrow_code = up_code_reg;
            ARROW_DOWN:  arrow_code = down_code_reg;
            ARROW_RIGHT: arrow_code = right_code_reg;
            ARROW_LEFT:  arrow_code = left_code_reg;
            default:     arrow_code = up_code_reg;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        line_mode_next   = line_mode_reg;
        up_code_next     = up_code_reg;
        down_code_next   = down_code_reg;
        right_code_next  = right_code_reg;
        left_code_next   = left_code_reg;
        fifo_wr_ptr_next = fifo_wr_ptr_reg;
        fifo_rd_ptr_next = fifo_rd_ptr_reg;
        fifo_count_next  = fifo_count_reg;
        write_bank_next  = write_bank_reg;
        write_len_next   = write_len_reg;
        read_len_next    = read_len_reg;
        read_pos_next    = read_pos_reg;
        read_active_next = read_active_reg;
        esc_seen_next    = esc_seen_reg;
        csi_seen_next    = csi_seen_reg;
        fifo_we          = 1'b0;
        fifo_wdata       = cur_reg.ch;
        line_we          = 1'b0;
        emit             = 1'b0;
        e_kind           = KIND_QUIET;
        e_data           = CH_NUL;
        e_dropped        = 1'b0;
        e_last           = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (q.valid)
                begin
                    cur_next   = q.word;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (cur_reg.op == OP_RECV)
                    begin
                        if (!line_mode_reg && fifo_count_reg == CW'(FIFO_DEPTH))
                        begin
                            e_dropped = 1'b1;
                        end
                        else if (esc_seen_reg && cur_reg.is_bracket)
                        begin
                            esc_seen_next = 1'b0;
                            csi_seen_next = 1'b1;
                        end
                        else if (csi_seen_reg)
                        begin
                            csi_seen_next = 1'b0;
                            if (!line_mode_reg && cur_reg.is_arrow)
                            begin
                                fifo_we    = 1'b1;
                                fifo_wdata = arrow_code;
                            end
                            else
                            begin
                                e_dropped = 1'b1;
                            end
                        end
                        else if (!line_mode_reg)
                        begin
                            esc_seen_next = cur_reg.is_esc;
                            fifo_we       = !cur_reg.is_esc;
                        end
                        else
                        begin
                            esc_seen_next = 1'b0;
                            if (cur_reg.is_nl)
                            begin
                                if (read_active_reg)
                                begin
                                    e_dropped = 1'b1;
                                end
                                else
                                begin
                                    read_len_next    = write_len_reg;
                                    write_bank_next  = !write_bank_reg;
                                    write_len_next   = '0;
                                    read_pos_next    = '0;
                                    read_active_next = 1'b1;
                                    e_kind           = KIND_ECHO;
                                    e_data           = CH_LF;
                                end
                            end
                            else if (cur_reg.is_del)
                            begin
                                if (write_len_reg == '0)
                                begin
                                    e_dropped = 1'b1;
                                end
                                else
                                begin
                                    write_len_next = write_len_reg - 1'b1;
                                    e_kind         = KIND_ECHO;
                                    e_data         = CH_BS;
                                    e_last         = 1'b0;
                                    state_next     = S_DEL_SPACE;
                                end
                            end
                            else if (cur_reg.is_esc)
                            begin
                                esc_seen_next = 1'b1;
                            end
                            else if (write_len_reg == LW'(LINE_LEN - 1))
                            begin
                                e_dropped = 1'b1;
                            end
                            else
                            begin
                                line_we        = 1'b1;
                                write_len_next = write_len_reg + 1'b1;
                                e_kind         = KIND_ECHO;
                                e_data         = cur_reg.ch;
                            end
                        end
                    end
                    else if (!line_mode_reg)
                    begin
                        if (fifo_count_reg == '0)
                        begin
                            e_kind = KIND_EMPTY;
                        end
                        else
                        begin
                            fifo_rd_ptr_next = (fifo_rd_ptr_reg == PW'(FIFO_DEPTH - 1)) ?
                                               '0 : fifo_rd_ptr_reg + 1'b1;
                            fifo_count_next  = fifo_count_reg - 1'b1;
                            e_kind           = KIND_READ;
                            e_data           = fifo_rd_data_reg;
                        end
                    end
                    else
                    begin
                        if (!read_active_reg)
                        begin
                            e_kind = KIND_EMPTY;
                        end
                        else
                        begin
                            e_kind = KIND_READ;
                            e_data = line_d;
                            if (line_d == CH_NUL)
                            begin
                                read_active_next = 1'b0;
                                read_pos_next    = '0;
                            end
                            else
                            begin
                                read_pos_next = read_pos_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            S_DEL_SPACE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_ECHO;
                    e_data     = CH_SPACE;
                    e_last     = 1'b0;
                    state_next = S_DEL_BS;
                end
            end
            S_DEL_BS:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_ECHO;
                    e_data     = CH_BS;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fifo_we)
        begin
            fifo_wr_ptr_next = (fifo_wr_ptr_reg == PW'(FIFO_DEPTH - 1)) ?
                               '0 : fifo_wr_ptr_reg + 1'b1;
            fifo_count_next  = fifo_count_reg + 1'b1;
        end

        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        data_next      = data_reg;
        dropped_next   = dropped_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            kind_next      = e_kind;
            data_next      = e_data;
            dropped_next   = e_dropped;
            last_next      = e_last;
        end

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_LINE_MODE:
                begin
                    line_mode_next   = cfg_data[0];
                    fifo_wr_ptr_next = '0;
                    fifo_rd_ptr_next = '0;
                    fifo_count_next  = '0;
                    write_bank_next  = 1'b0;
                    write_len_next   = '0;
                    read_len_next    = '0;
                    read_pos_next    = '0;
                    read_active_next = 1'b0;
                    esc_seen_next    = 1'b0;
                    csi_seen_next    = 1'b0;
                end
                CFG_ARROW_UP:    up_code_next    = cfg_data;
                CFG_ARROW_DOWN:  down_code_next  = cfg_data;
                CFG_ARROW_RIGHT: right_code_next = cfg_data;
                CFG_ARROW_LEFT:  left_code_next  = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            line_mode_reg   <= 1'b0;
            up_code_reg     <= ARROW_UP_RESET;
            down_code_reg   <= ARROW_DOWN_RESET;
            right_code_reg  <= ARROW_RIGHT_RESET;
            left_code_reg   <= ARROW_LEFT_RESET;
            fifo_wr_ptr_reg <= '0;
            fifo_rd_ptr_reg <= '0;
            fifo_count_reg  <= '0;
            write_bank_reg  <= 1'b0;
            write_len_reg   <= '0;
            read_len_reg    <= '0;
            read_pos_reg    <= '0;
            read_active_reg <= 1'b0;
            esc_seen_reg    <= 1'b0;
            csi_seen_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            line_mode_reg   <= line_mode_next;
            up_code_reg     <= up_code_next;
            down_code_reg   <= down_code_next;
            right_code_reg  <= right_code_next;
            left_code_reg   <= left_code_next;
            fifo_wr_ptr_reg <= fifo_wr_ptr_next;
            fifo_rd_ptr_reg <= fifo_rd_ptr_next;
            fifo_count_reg  <= fifo_count_next;
            write_bank_reg  <= write_bank_next;
            write_len_reg   <= write_len_next;
            read_len_reg    <= read_len_next;
            read_pos_reg    <= read_pos_next;
            read_active_reg <= read_active_next;
            esc_seen_reg    <= esc_seen_next;
            csi_seen_reg    <= csi_seen_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        kind_reg    <= kind_next;
        data_reg    <= data_next;
        dropped_reg <= dropped_next;
        last_reg    <= last_next;
    end

    // character fifo
    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[fifo_wr_ptr_reg] <= fifo_wdata;
        end
        fifo_rd_data_reg <= fifo_mem[fifo_rd_ptr_reg];
    end

    // two line banks
    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_waddr] <= cur_reg.ch;
        end
        line_rd_data_reg <= line_mem[line_raddr];
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign dropped   = dropped_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// File: rtl/core/terminal_input_line_discipline_core.sv
// top level of the terminal input line discipline
`default_nettype none

// Takes received characters and read requests and returns echo, read and status
// words. A two-word input queue decouples the classifying front end from the
// execution engine, so new words are taken while earlier ones are still being
// handled. Each word passes an idle step (one registered read of the fifo or line
// memory) and an execute step (state update and first result); an accepted DEL
// then passes DEL_SPACE and DEL_BS for its extra echo words. Output stall holds
// the engine. Configuration must be written only while the block is idle; the
// block itself does not enforce this. Writing the mode register empties the
// fifo and both line banks. The memories need no clearing after reset.
module terminal_input_line_discipline_core
#(
    parameter int FIFO_DEPTH = 16,
    parameter int LINE_LEN   = 64
)
(
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire                            operation,
    input  wire  [7:0]                     char_in,
    output logic                           out_valid,
    input  wire                            out_stall,
    output logic [1:0]                     kind,
    output logic [7:0]                     data,
    output logic                           dropped,
    output logic                           last,
    input  wire                            cfg_write,
    input  wire  [tild_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [7:0]                     cfg_data
);
    import tild_pkg::*;

    tild_queue_t q;
    logic        q_pop;

    tild_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .char_in   (char_in),
        .q         (q),
        .q_pop     (q_pop)
    );

    tild_back
    #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .LINE_LEN   (LINE_LEN)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q         (q),
        .q_pop     (q_pop),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data      (data),
        .dropped   (dropped),
        .last      (last)
    );

`include "assert_macros.svh"

    `ASSERT_IMPLY(a_pop_needs_word, clk, rst_n, q_pop, q.valid)
    `ASSERT_NEXT(a_accept_fills_queue, clk, rst_n, in_valid && !in_stall && !q.valid, q.valid)
    `ASSERT_NEXT(a_no_back_to_back_pop, clk, rst_n, q_pop, !q_pop)

endmodule

`default_nettype wire

// File: bench/terminal_input_line_discipline_core_checker.sv
// checker: predicts every result word of the line discipline and compares it with the block
`timescale 1ns / 1ps

module terminal_input_line_discipline_core_checker
(
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    input  wire                            in_stall,
    input  wire                            operation,
    input  wire  [7:0]                     char_in,
    input  wire                            out_valid,
    input  wire                            out_stall,
    input  wire  [1:0]                     kind,
    input  wire  [7:0]                     data,
    input  wire                            dropped,
    input  wire                            last,
    input  wire                            cfg_write,
    input  wire  [tild_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [7:0]                     cfg_data,
    output int                             errors,
    output int                             pending
);

    import tild_pkg::*;

    localparam int FIFO_SLOTS = 16;
    localparam int LINE_SLOTS = 64;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       dropped;
        logic       last;
    } outcome_t;

    logic       line_mode_q;
    logic [7:0] arrow_code [4];
    logic [7:0] fifo_mem [FIFO_SLOTS];
    logic [3:0] fifo_wr;
    logic [3:0] fifo_rd;
    logic [4:0] fifo_cnt;
    logic [7:0] line_mem [2*LINE_SLOTS];
    logic       wr_bank;
    logic [5:0] wr_len;
    logic [5:0] rd_len;
    logic [5:0] rd_pos;
    logic       rd_active;
    logic       esc_flag;
    logic       csi_flag;
    outcome_t   outcome_q [$];

    task automatic queue_outcome(input kind_t k, input logic [7:0] d, input logic dr,
                                 input logic l);
        outcome_t o;
        o.kind    = k;
        o.data    = d;
        o.dropped = dr;
        o.last    = l;
        outcome_q.push_back(o);
    endtask

    task automatic clear_edit_state();
        fifo_wr   = '0;
        fifo_rd   = '0;
        fifo_cnt  = '0;
        wr_bank   = 1'b0;
        wr_len    = '0;
        rd_len    = '0;
        rd_pos    = '0;
        rd_active = 1'b0;
        esc_flag  = 1'b0;
        csi_flag  = 1'b0;
    endtask

    task automatic fifo_put(input logic [7:0] v);
        fifo_mem[fifo_wr] = v;
        fifo_wr = fifo_wr + 4'd1;
        fifo_cnt = fifo_cnt + 5'd1;
    endtask

    task automatic predict_word(input logic op, input logic [7:0] ch);
        logic [7:0] rd;
        rd = CH_NUL;
        if (op == OP_RECV && !line_mode_q) begin
            if (fifo_cnt >= FIFO_SLOTS) begin
                queue_outcome(KIND_QUIET, CH_NUL, 1'b1, 1'b1);
            end
            else if (esc_flag && ch == CH_BRACKET) begin
                esc_flag = 1'b0;
                csi_flag = 1'b1;
                queue_outcome(KIND_QUIET, CH_NUL, 1'b0, 1'b1);
            end
            else if (csi_flag) begin
                csi_flag = 1'b0;
                if (ch >= CH_A && ch <= CH_D) begin
                    fifo_put(arrow_code[2'(ch - CH_A)]);
                    queue_outcome(KIND_QUIET, CH_NUL, 1'b0, 1'b1);
                end
                else begin
                    queue_outcome(KIND_QUIET, CH_NUL, 1'b1, 1'b1);
                end
            end
            else begin
                esc_flag = 1'b0;
                if (ch == CH_ESC)
                    esc_flag = 1'b1;
                else
                    fifo_put(ch);
                queue_outcome(KIND_QUIET, CH_NUL, 1'b0, 1'b1);
            end
        end
        else if (op == OP_RECV) begin
            if (esc_flag && ch == CH_BRACKET) begin
                esc_flag = 1'b0;
                csi_flag = 1'b1;
                queue_outcome(KIND_QUIET, CH_NUL, 1'b0, 1'b1);
            end
            else if (csi_flag) begin
                csi_flag = 1'b0;
                queue_outcome(KIND_QUIET, CH_NUL, 1'b1, 1'b1);
            end
            else begin
                esc_flag = 1'b0;
                if (ch == CH_LF || ch == CH_CR) begin
                    if (rd_active) begin
                        queue_outcome(KIND_QUIET, CH_NUL, 1'b1, 1'b1);
                    end
                    else begin
                        rd_len    = wr_len;
                        wr_bank   = ~wr_bank;
                        wr_len    = '0;
                        rd_pos    = '0;
                        rd_active = 1'b1;
                        queue_outcome(KIND_ECHO, CH_LF, 1'b0, 1'b1);
                    end
                end
                else if (ch == CH_DEL) begin
                    if (wr_len == 0) begin
                        queue_outcome(KIND_QUIET, CH_NUL, 1'b1, 1'b1);
                    end
                    else begin
                        wr_len = wr_len - 6'd1;
                        queue_outcome(KIND_ECHO, CH_BS, 1'b0, 1'b0);
                        queue_outcome(KIND_ECHO, CH_SPACE, 1'b0, 1'b0);
                        queue_outcome(KIND_ECHO, CH_BS, 1'b0, 1'b1);
                    end
                end
                else if (ch == CH_ESC) begin
                    esc_flag = 1'b1;
                    queue_outcome(KIND_QUIET, CH_NUL, 1'b0, 1'b1);
                end
                else if (wr_len >= LINE_SLOTS - 1) begin
                    queue_outcome(KIND_QUIET, CH_NUL, 1'b1, 1'b1);
                end
                else begin
                    line_mem[{wr_bank, wr_len}] = ch;
                    wr_len = wr_len + 6'd1;
                    queue_outcome(KIND_ECHO, ch, 1'b0, 1'b1);
                end
            end
        end
        else if (!line_mode_q) begin
            if (fifo_cnt == 0) begin
                queue_outcome(KIND_EMPTY, CH_NUL, 1'b0, 1'b1);
            end
            else begin
                rd = fifo_mem[fifo_rd];
                fifo_rd = fifo_rd + 4'd1;
                fifo_cnt = fifo_cnt - 5'd1;
                queue_outcome(KIND_READ, rd, 1'b0, 1'b1);
            end
        end
        else begin
            if (!rd_active) begin
                queue_outcome(KIND_EMPTY, CH_NUL, 1'b0, 1'b1);
            end
            else begin
                if (rd_pos < rd_len)
                    rd = line_mem[{~wr_bank, rd_pos}];
                // a nul ends the line and frees the read bank
                if (rd == CH_NUL) begin
                    rd_active = 1'b0;
                    rd_pos    = '0;
                end
                else begin
                    rd_pos = rd_pos + 6'd1;
                end
                queue_outcome(KIND_READ, rd, 1'b0, 1'b1);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            line_mode_q   = 1'b0;
            arrow_code[0] = ARROW_UP_RESET;
            arrow_code[1] = ARROW_DOWN_RESET;
            arrow_code[2] = ARROW_RIGHT_RESET;
            arrow_code[3] = ARROW_LEFT_RESET;
            clear_edit_state();
            outcome_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_LINE_MODE)
                begin
                    line_mode_q = cfg_data[0];
                    clear_edit_state();
                end
                else if (cfg_index >= CFG_ARROW_UP && cfg_index <= CFG_ARROW_LEFT)
                begin
                    arrow_code[2'(cfg_index - CFG_ARROW_UP)] = cfg_data;
                end
            end
            if (in_valid && !in_stall)
                predict_word(operation, char_in);
            if (out_valid && !out_stall)
            begin
                if (outcome_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result word: kind %0d data %02h dropped %0d last %0d",
                                 kind, data, dropped, last);
                    errors++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (kind !== want.kind || data !== want.data ||
                        dropped !== want.dropped || last !== want.last)
                    begin
                        if (errors < 10)
                            $display({"mismatch: expected kind %0d data %02h dropped %0d last %0d,",
                                      " got kind %0d data %02h dropped %0d last %0d"},
                                     want.kind, want.data, want.dropped, want.last,
                                     kind, data, dropped, last);
                        errors++;
                    end
                end
            end
            pending = outcome_q.size();
        end
    end

endmodule

// File: bench/terminal_input_line_discipline_core_tb.sv
// testbench top: drives characters, reads and register writes into the line discipline
`timescale 1ns / 1ps

module terminal_input_line_discipline_core_tb;

    import tild_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_TARGET = 380;
    localparam int PHASE_ITEMS   = 50;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 operation = 1'b0;
    logic [7:0]           char_in   = 8'd0;
    logic                 out_stall = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = 8'd0;
    logic                 hold_req  = 1'b0;
    wire                  in_stall;
    wire                  out_valid;
    wire  [1:0]           kind;
    wire  [7:0]           data;
    wire                  dropped;
    wire                  last;
    int                   errors;
    int                   pending;
    int                   burst_left;
    int                   items_sent;
    int                   cycle_count;

    terminal_input_line_discipline_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .char_in   (char_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data      (data),
        .dropped   (dropped),
        .last      (last),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    terminal_input_line_discipline_core_checker u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .char_in   (char_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data      (data),
        .dropped   (dropped),
        .last      (last),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic send_word(input logic op, input logic [7:0] ch);
        if (burst_left <= 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        char_in   <= ch;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_reads(input int n);
        repeat (n) send_word(OP_READ, 8'($urandom_range(0, 255)));
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // receiver stall patterns, plus one long hold-off on request
    initial
    begin
        int seg_left;
        int pattern;
        int hold_left;
        logic hold_done;
        logic toggle;
        seg_left  = 0;
        pattern   = 0;
        hold_left = 0;
        hold_done = 1'b0;
        toggle    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (seg_left == 0)
            begin
                pattern  = $urandom_range(0, 3);
                seg_left = $urandom_range(10, 60);
            end
            seg_left--;
            toggle = ~toggle;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (pattern == 0)
                out_stall <= 1'b0;
            else if (pattern == 1)
                out_stall <= ($urandom_range(0, 3) == 0);
            else if (pattern == 2)
                out_stall <= toggle;
            else
                out_stall <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("terminal_input_line_discipline_core_tb: errors");
        $finish;
    end

    initial
    begin
        int phase;
        int phase_start;
        int pick;
        int pick2;
        int line_len;
        int i;
        int k;
        logic mode_sel;
        logic long_line;
        logic [7:0] code;
        burst_left = 0;
        items_sent = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // direct mode with reset arrow codes
        send_reads(1);
        send_word(OP_RECV, 8'h00);
        send_word(OP_RECV, 8'hff);
        send_word(OP_RECV, 8'h61);
        for (k = 0; k < 4; k++)
        begin
            send_word(OP_RECV, CH_ESC);
            send_word(OP_RECV, CH_BRACKET);
            send_word(OP_RECV, 8'(CH_A + k));
        end
        send_word(OP_RECV, CH_ESC);
        send_word(OP_RECV, CH_BRACKET);
        send_word(OP_RECV, 8'h78);
        send_word(OP_RECV, CH_ESC);
        send_word(OP_RECV, 8'h71);
        send_reads(9);

        // line mode editing
        settle();
        cfg_put(CFG_LINE_MODE, 8'h01);
        send_word(OP_RECV, CH_DEL);
        send_word(OP_RECV, 8'h68);
        send_word(OP_RECV, 8'h69);
        send_word(OP_RECV, CH_DEL);
        send_word(OP_RECV, CH_ESC);
        send_word(OP_RECV, CH_BRACKET);
        send_word(OP_RECV, CH_A);
        send_word(OP_RECV, CH_ESC);
        send_word(OP_RECV, 8'h7a);
        send_word(OP_RECV, CH_CR);
        send_word(OP_RECV, CH_LF);
        send_reads(4);
        send_word(OP_RECV, 8'h78);
        send_word(OP_RECV, CH_NUL);
        send_word(OP_RECV, 8'h79);
        send_word(OP_RECV, CH_LF);
        send_reads(3);

        phase = 0;
        while (items_sent < RANDOM_TARGET)
        begin
            settle();
            mode_sel = phase[1];
            cfg_put(CFG_LINE_MODE, {7'($urandom_range(0, 127)), mode_sel});
            for (k = 0; k < 4; k++)
            begin
                if (phase == 0)
                    code = 8'h00;
                else if (phase == 1)
                    code = 8'hff;
                else
                    code = 8'($urandom_range(0, 255));
                if (phase < 2 || $urandom_range(0, 2) != 0)
                    cfg_put(3'(CFG_ARROW_UP + k), code);
            end
            if ($urandom_range(0, 2) == 0)
                cfg_put(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)));
            if (phase == 1)
                hold_req = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (!mode_sel)
                begin
                    if (pick < 30)
                        send_word(OP_RECV, 8'($urandom_range(0, 255)));
                    else if (pick < 45)
                        send_reads($urandom_range(1, 4));
                    else if (pick < 57)
                    begin
                        send_word(OP_RECV, CH_ESC);
                        send_word(OP_RECV, CH_BRACKET);
                        send_word(OP_RECV, 8'(CH_A + $urandom_range(0, 3)));
                    end
                    else if (pick < 63)
                    begin
                        send_word(OP_RECV, CH_ESC);
                        send_word(OP_RECV, CH_BRACKET);
                        send_word(OP_RECV, 8'($urandom_range(0, 255)));
                    end
                    else if (pick < 69)
                    begin
                        send_word(OP_RECV, CH_ESC);
                        send_word(OP_RECV, 8'($urandom_range(0, 255)));
                    end
                    else if (pick < 75)
                    begin
                        // overfill, escape bytes included
                        for (i = 0; i < 18; i++)
                        begin
                            pick2 = $urandom_range(0, 7);
                            if (pick2 == 0)
                                send_word(OP_RECV, CH_ESC);
                            else if (pick2 == 1)
                                send_word(OP_RECV, CH_BRACKET);
                            else
                                send_word(OP_RECV, 8'($urandom_range(0, 255)));
                        end
                        send_reads($urandom_range(0, 18));
                    end
                    else if (pick < 82)
                        send_reads(18);
                    else
                        send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
                else
                begin
                    if (pick < 55)
                    begin
                        long_line = (phase == 2 && items_sent == phase_start) ||
                                    ($urandom_range(0, 11) == 0);
                        if (long_line)
                        begin
                            // past the line limit, then edit while full
                            for (i = 0; i < 66; i++)
                                send_word(OP_RECV, 8'($urandom_range(32, 126)));
                            send_word(OP_RECV, CH_DEL);
                            send_word(OP_RECV, 8'($urandom_range(32, 126)));
                            send_word(OP_RECV, 8'($urandom_range(32, 126)));
                            line_len = 63;
                        end
                        else
                        begin
                            line_len = $urandom_range(0, 10);
                            for (i = 0; i < line_len; i++)
                            begin
                                pick2 = $urandom_range(0, 99);
                                if (pick2 < 12)
                                    send_word(OP_RECV, CH_DEL);
                                else if (pick2 < 16)
                                begin
                                    send_word(OP_RECV, CH_ESC);
                                    send_word(OP_RECV, CH_BRACKET);
                                    send_word(OP_RECV, 8'($urandom_range(0, 255)));
                                end
                                else if (pick2 < 19)
                                begin
                                    send_word(OP_RECV, CH_ESC);
                                    send_word(OP_RECV, 8'($urandom_range(32, 126)));
                                end
                                else if (pick2 < 27)
                                    send_word(OP_RECV, 8'($urandom_range(0, 255)));
                                else
                                    send_word(OP_RECV, 8'($urandom_range(32, 126)));
                            end
                        end
                        send_word(OP_RECV, ($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
                        if ($urandom_range(0, 3) == 0)
                            send_word(OP_RECV, CH_LF);
                        if ($urandom_range(0, 4) == 0)
                            send_reads($urandom_range(0, line_len));
                        else
                            send_reads(line_len + $urandom_range(1, 3));
                    end
                    else if (pick < 70)
                        send_reads($urandom_range(1, 3));
                    else if (pick < 80)
                        repeat ($urandom_range(1, 4)) send_word(OP_RECV, CH_DEL);
                    else
                        send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
            end
            phase++;
        end

        settle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("terminal_input_line_discipline_core_tb: clean");
        else
            $display("terminal_input_line_discipline_core_tb: errors");
        $finish;
    end

endmodule
